/* design/fbpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // build defaults
    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_ADDRESS_BITS = 32;

    // free map is kept in rows of ROW_BITS blocks
    localparam int ROW_BITS  = 8;
    localparam int ROW_SEL_W = 3;

    // register field widths
    localparam int SIZE_W    = 17;
    localparam int BCNT_W    = 7;
    localparam int CFG_IDX_W = 2;

    // width used for block index / count compares
    localparam int CMP_W = 16;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = SIZE_W'(64);
    localparam logic [BCNT_W-1:0] RST_BLOCK_COUNT = BCNT_W'(64);

    // register index map
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EXHAUSTED    = 2'd1,
        ST_OUTSIDE      = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

endpackage
`default_nettype wire

/* design/fbpa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

/* design/fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Bitmap allocator for a pool of equal-size blocks: allocate / free requests.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  -------   ---------------------   ----------------------------------------
//  request   start & !busy           i_operation, i_free_address
//  result    o_done (1-cycle pulse)  o_status, o_block_address, o_free_blocks
//  config    i_cfg_we                i_cfg_index, i_cfg_data
//
//  Sequence: allocate holds busy while it reads and checks each map row
//    scanned (8 blocks a row), then while it forms the address; free
//    holds busy while it divides (one quotient bit per cycle from the
//    restore-divide unit), then reads and updates a map row.
//    o_done rises in the cycle busy falls.
//  Reset: synchronous, active low. After reset, and after every write of
//    block_count, a clearing pass writes ceil(MAX_BLOCKS/8) map rows, one a
//    cycle, with busy held high.
//  The receiver cannot stall: o_done and the payload are valid one cycle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1),
    localparam int CFG_W  = (ADDRESS_BITS > SIZE_W) ? ADDRESS_BITS : SIZE_W
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    i_operation,
    input  wire logic [ADDRESS_BITS-1:0] i_free_address,
    // result
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [ADDRESS_BITS-1:0]      o_block_address,
    output logic [CNT_W-1:0]             o_free_blocks,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data
);

    // map geometry
    localparam int ROWS   = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_AW + ROW_SEL_W;
    localparam int PROD_W = IDX_W + SIZE_W;
    localparam int STEP_W = $clog2(ADDRESS_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_SUB,
        S_DIV,
        S_FREE_RD,
        S_FREE_WAIT,
        S_FREE_CHK
    } t_state;

    t_state r_state;

    // configuration registers
    logic [ADDRESS_BITS-1:0] r_base;
    logic [SIZE_W-1:0]       r_blk_size;
    logic [BCNT_W-1:0]       r_blk_count;

    // work registers
    logic [CNT_W-1:0]        r_free_total;
    logic [ROW_AW-1:0]       r_row;
    logic [ROW_SEL_W-1:0]    r_bit;
    logic [IDX_W-1:0]        r_idx;
    logic [PROD_W-1:0]       r_prod;
    logic [ADDRESS_BITS-1:0] r_faddr;
    logic [ADDRESS_BITS-1:0] r_quo;     // dividend in, quotient out
    logic [SIZE_W-1:0]       r_rem;
    logic [STEP_W-1:0]       r_step;

    // result registers
    logic                    r_done;
    t_status                 r_status;
    logic [ADDRESS_BITS-1:0] r_baddr;

    // effective size and count
    logic [SIZE_W-1:0] w_size;
    logic [CMP_W-1:0]  w_cnt16;
    logic [CNT_W-1:0]  w_cnt;

    always_comb begin
        w_size = (r_blk_size == '0) ? SIZE_W'(1) : r_blk_size;
        if (r_blk_count == '0) begin
            w_cnt16 = CMP_W'(1);
        end else if (CMP_W'(r_blk_count) > CMP_W'(MAX_BLOCKS)) begin
            w_cnt16 = CMP_W'(MAX_BLOCKS);
        end else begin
            w_cnt16 = CMP_W'(r_blk_count);
        end
        w_cnt = CNT_W'(w_cnt16);
    end

    // free map RAM: one bit per block, 1 = used
    logic                w_ram_we;
    logic [ROW_BITS-1:0] w_ram_wdata;
    logic [ROW_BITS-1:0] w_ram_rdata;

    fbpa_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (r_row),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // row scan: lowest free block below the count
    logic [ROW_BITS-1:0]  w_avail;
    logic                 w_hit;
    logic [ROW_SEL_W-1:0] w_sel;
    logic                 w_more_rows;

    always_comb begin
        for (int j = 0; j < ROW_BITS; j++) begin
            w_avail[j] = !w_ram_rdata[j]
                && (CMP_W'({r_row, ROW_SEL_W'(j)}) < w_cnt16);
        end
        w_hit = 1'b0;
        w_sel = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--) begin
            if (w_avail[j]) begin
                w_hit = 1'b1;
                w_sel = ROW_SEL_W'(j);
            end
        end
        w_more_rows = (CMP_W'({r_row, ROW_SEL_W'(0)}) + CMP_W'(ROW_BITS)) < w_cnt16;
    end

    // map write port
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we = 1'b1;
            end
            S_ALLOC_CHK: begin
                w_ram_we    = w_hit;
                w_ram_wdata = w_ram_rdata | (ROW_BITS'(1) << w_sel);
            end
            S_FREE_CHK: begin
                w_ram_we    = w_ram_rdata[r_bit];
                w_ram_wdata = w_ram_rdata & ~(ROW_BITS'(1) << r_bit);
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // restoring divide step: one quotient bit a cycle
    logic [SIZE_W:0]   w_trial;
    logic              w_ge;
    logic [SIZE_W-1:0] w_rem_next;

    always_comb begin
        w_trial    = {r_rem, r_quo[ADDRESS_BITS-1]};
        w_ge       = w_trial >= {1'b0, w_size};
        w_rem_next = w_ge ? SIZE_W'(w_trial - {1'b0, w_size}) : SIZE_W'(w_trial);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_row        <= '0;
            r_done       <= 1'b0;
            r_status     <= ST_OK;
            r_base       <= '0;
            r_blk_size   <= RST_BLOCK_SIZE;
            r_blk_count  <= RST_BLOCK_COUNT;
            r_free_total <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_row   <= '0;
                        r_faddr <= i_free_address;
                        r_state <= (i_operation == OP_FREE) ? S_FREE_SUB : S_ALLOC_RD;
                    end
                end
                S_CLEAR: begin
                    // every block free, count back to the effective block count
                    if (r_row == ROW_AW'(ROWS - 1)) begin
                        r_free_total <= w_cnt;
                        r_row        <= '0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_row <= r_row + ROW_AW'(1);
                    end
                end
                S_ALLOC_RD: begin
                    r_state <= S_ALLOC_CHK;
                end
                S_ALLOC_CHK: begin
                    if (w_hit) begin
                        r_idx        <= {r_row, w_sel};
                        r_free_total <= r_free_total - CNT_W'(1);
                        r_state      <= S_ALLOC_MUL;
                    end else if (w_more_rows) begin
                        r_row   <= r_row + ROW_AW'(1);
                        r_state <= S_ALLOC_RD;
                    end else begin
                        r_status <= ST_EXHAUSTED;
                        r_baddr  <= '0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_ALLOC_MUL: begin
                    r_prod  <= PROD_W'(r_idx) * PROD_W'(w_size);
                    r_state <= S_ALLOC_ADD;
                end
                S_ALLOC_ADD: begin
                    // wraps modulo the address width
                    r_baddr  <= r_base + ADDRESS_BITS'(r_prod);
                    r_status <= ST_OK;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_FREE_SUB: begin
                    if (r_faddr < r_base) begin
                        r_status <= ST_OUTSIDE;
                        r_baddr  <= '0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_quo   <= r_faddr - r_base;
                        r_rem   <= '0;
                        r_step  <= STEP_W'(ADDRESS_BITS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_next;
                    r_quo <= {r_quo[ADDRESS_BITS-2:0], w_ge};
                    if (r_step == '0) begin
                        r_state <= S_FREE_RD;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_FREE_RD: begin
                    // index past the count is outside the pool
                    if (r_quo >= ADDRESS_BITS'(w_cnt16)) begin
                        r_status <= ST_OUTSIDE;
                        r_baddr  <= '0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_row   <= r_quo[IDX_W-1:ROW_SEL_W];
                        r_bit   <= r_quo[ROW_SEL_W-1:0];
                        r_state <= S_FREE_WAIT;
                    end
                end
                S_FREE_WAIT: begin
                    // map row read at the new row address
                    r_state <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    if (w_ram_rdata[r_bit]) begin
                        r_free_total <= r_free_total + CNT_W'(1);
                        r_status     <= ST_OK;
                    end else begin
                        r_status <= ST_ALREADY_FREE;
                    end
                    r_baddr <= '0;
                    r_done  <= 1'b1;
                    r_row   <= '0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes are to arrive only while idle; the block does not enforce this
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE: begin
                        r_base <= i_cfg_data[ADDRESS_BITS-1:0];
                    end
                    CFG_SIZE: begin
                        r_blk_size <= i_cfg_data[SIZE_W-1:0];
                    end
                    CFG_COUNT: begin
                        r_blk_count <= i_cfg_data[BCNT_W-1:0];
                        r_row       <= '0;
                        r_state     <= S_CLEAR;
                    end
                    default: begin
                        r_base <= r_base;
                    end
                endcase
            end
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_block_address = r_baddr;
    assign o_free_blocks   = r_free_total;

endmodule
`default_nettype wire
